// ===== hw/rtl/tcie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcie_pkg
// Shared types, opcodes and sizes for the toy instruction executor.
// ----------------------------------------------------------------------------
package tcie_pkg;

  // Sizes
  localparam int NUM_REGS   = 16;
  localparam int RIDX_W     = $clog2(NUM_REGS);
  // Data memory depth, a power of two from 16 to 256
  localparam int DMEM_DEPTH = 256;
  localparam int DMEM_AW    = $clog2(DMEM_DEPTH);

  typedef logic [7:0]         byte_t;
  typedef logic [RIDX_W-1:0]  reg_idx_t;
  typedef logic [DMEM_AW-1:0] dmem_idx_t;

  // Request function codes
  localparam logic [1:0] FUNC_EXEC  = 2'd0;
  localparam logic [1:0] FUNC_LDREG = 2'd1;
  localparam logic [1:0] FUNC_LDMEM = 2'd2;
  localparam logic [1:0] FUNC_RDMEM = 2'd3;

  // Opcodes (12 to 14 are unassigned and flagged)
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_INC   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_OR    = 4'd5;
  localparam logic [3:0] OP_NOT   = 4'd6;
  localparam logic [3:0] OP_XOR   = 4'd7;
  localparam logic [3:0] OP_LOAD  = 4'd8;
  localparam logic [3:0] OP_STORE = 4'd9;
  localparam logic [3:0] OP_JUMP  = 4'd10;
  localparam logic [3:0] OP_BEQZ  = 4'd11;
  localparam logic [3:0] OP_HALT  = 4'd15;

  // Request payload
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] instr;
    byte_t       addr;
    byte_t       wdata;
  } req_t;

  // Result payload
  typedef struct packed {
    byte_t    next_pc;
    logic     halted;
    logic     bad_opcode;
    logic     branch_taken;
    logic     reg_we;
    reg_idx_t reg_index;
    byte_t    reg_value;
    logic     mem_we;
    byte_t    mem_addr;
    byte_t    mem_value;
    byte_t    read_data;
  } res_t;

  // Data memory access
  typedef struct packed {
    logic      we;
    logic      re;
    dmem_idx_t idx;
    byte_t     wdata;
  } dmem_req_t;

  // Execute stage outcome
  typedef struct packed {
    res_t      res;
    dmem_req_t mem;
    logic      is_load;
    logic      is_read;
    byte_t     pc_next;
    logic      halt_next;
  } exec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tcie_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcie_regfile
// 16 x 8 register file, two copies for three read ports, registered reads
// with same-edge write bypass; valid bits give the all-zero reset.
// ----------------------------------------------------------------------------
module tcie_regfile (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire tcie_pkg::reg_idx_t r1,
  input  wire tcie_pkg::reg_idx_t r2,
  input  wire tcie_pkg::reg_idx_t r3,
  input  wire logic              we,
  input  wire tcie_pkg::reg_idx_t widx,
  input  wire tcie_pkg::byte_t   wval,
  output tcie_pkg::byte_t        rd1,
  output tcie_pkg::byte_t        rd2,
  output tcie_pkg::byte_t        rd3
);

  tcie_pkg::byte_t                 rf_a [tcie_pkg::NUM_REGS];
  tcie_pkg::byte_t                 rf_b [tcie_pkg::NUM_REGS];
  logic [tcie_pkg::NUM_REGS-1:0]   vld;

  // Written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[widx] <= 1'b1;
    end
  end

  // Both copies take every write
  always_ff @(posedge clk) begin
    if (we) begin
      rf_a[widx] <= wval;
      rf_b[widx] <= wval;
    end
  end

  // Copy A serves r2/r3, copy B serves r1
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd2 <= (we && widx == r2) ? wval : (vld[r2] ? rf_a[r2] : '0);
      rd3 <= (we && widx == r3) ? wval : (vld[r3] ? rf_a[r3] : '0);
      rd1 <= (we && widx == r1) ? wval : (vld[r1] ? rf_b[r1] : '0);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tcie_dmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcie_dmem
// Byte-wide data memory, one access per cycle, registered read; per-entry
// valid bits make unwritten bytes read as zero after reset.
// ----------------------------------------------------------------------------
module tcie_dmem (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire tcie_pkg::dmem_req_t req,
  output tcie_pkg::byte_t          rdata
);

  tcie_pkg::byte_t                  mem [tcie_pkg::DMEM_DEPTH];
  logic [tcie_pkg::DMEM_DEPTH-1:0]  vld;
  tcie_pkg::byte_t                  rd_q;
  logic                             rd_vld_q;

  // Written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en && req.we) begin
      vld[req.idx] <= 1'b1;
    end
  end

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (en && req.we) begin
      mem[req.idx] <= req.wdata;
    end
    if (en && req.re) begin
      rd_q     <= mem[req.idx];
      rd_vld_q <= vld[req.idx];
    end
  end

  assign rdata = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/tcie_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcie_exec
// Decode and execute for one request: ALU, effective address, next pc,
// halt handling and the data memory access it needs.
// ----------------------------------------------------------------------------
module tcie_exec (
  input  wire tcie_pkg::req_t  req,
  input  wire tcie_pkg::byte_t op_a,   // reg[r2]
  input  wire tcie_pkg::byte_t op_b,   // reg[r3]
  input  wire tcie_pkg::byte_t op_c,   // reg[r1]
  input  wire tcie_pkg::byte_t pc,
  input  wire logic            halt,
  output tcie_pkg::exec_t      ex
);

  logic [3:0]      opc;
  logic [15:0]     prod;
  tcie_pkg::byte_t ea;
  tcie_pkg::byte_t pc_inc;

  assign opc    = req.instr[15:12];
  assign prod   = op_a * op_b;
  // base plus sign-extended 4-bit offset
  assign ea     = op_a + {{4{req.instr[3]}}, req.instr[3:0]};
  assign pc_inc = pc + 8'd2;

  always_comb begin
    ex           = '0;
    ex.pc_next   = pc;
    ex.halt_next = halt;

    unique case (req.func)
      tcie_pkg::FUNC_LDREG: begin
        ex.res.reg_we    = 1'b1;
        ex.res.reg_index = req.addr[tcie_pkg::RIDX_W-1:0];
        ex.res.reg_value = req.wdata;
      end
      tcie_pkg::FUNC_LDMEM: begin
        ex.res.mem_we    = 1'b1;
        ex.res.mem_addr  = req.addr;
        ex.res.mem_value = req.wdata;
        ex.mem.we        = 1'b1;
        ex.mem.idx       = req.addr[tcie_pkg::DMEM_AW-1:0];
        ex.mem.wdata     = req.wdata;
      end
      tcie_pkg::FUNC_RDMEM: begin
        ex.is_read = 1'b1;
        ex.mem.re  = 1'b1;
        ex.mem.idx = req.addr[tcie_pkg::DMEM_AW-1:0];
      end
      tcie_pkg::FUNC_EXEC: begin
        // ignored while halted
        if (!halt) begin
          ex.pc_next       = pc_inc;
          ex.res.reg_index = req.instr[11:8];
          unique case (opc)
            tcie_pkg::OP_ADD: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_a + op_b;
            end
            tcie_pkg::OP_SUB: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_a - op_b;
            end
            tcie_pkg::OP_MUL: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = prod[7:0];
            end
            tcie_pkg::OP_INC: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_c + 8'd1;
            end
            tcie_pkg::OP_AND: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_a & op_b;
            end
            tcie_pkg::OP_OR: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_a | op_b;
            end
            tcie_pkg::OP_NOT: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = ~op_a;
            end
            tcie_pkg::OP_XOR: begin
              ex.res.reg_we = 1'b1; ex.res.reg_value = op_a ^ op_b;
            end
            tcie_pkg::OP_LOAD: begin
              // value arrives from the data memory one stage later
              ex.res.reg_we   = 1'b1;
              ex.res.mem_addr = ea;
              ex.is_load      = 1'b1;
              ex.mem.re       = 1'b1;
              ex.mem.idx      = ea[tcie_pkg::DMEM_AW-1:0];
            end
            tcie_pkg::OP_STORE: begin
              ex.res.mem_we    = 1'b1;
              ex.res.mem_addr  = ea;
              ex.res.mem_value = op_c;
              ex.mem.we        = 1'b1;
              ex.mem.idx       = ea[tcie_pkg::DMEM_AW-1:0];
              ex.mem.wdata     = op_c;
            end
            tcie_pkg::OP_JUMP: begin
              ex.pc_next          = pc_inc + {req.instr[10:4], 1'b0};
              ex.res.branch_taken = 1'b1;
            end
            tcie_pkg::OP_BEQZ: begin
              if (op_c == '0) begin
                ex.pc_next          = pc_inc + {req.instr[6:0], 1'b0};
                ex.res.branch_taken = 1'b1;
              end
            end
            tcie_pkg::OP_HALT: begin
              ex.halt_next = 1'b1;
            end
            default: begin
              // unassigned opcode: flag it, pc stays put
              ex.res.bad_opcode = 1'b1;
              ex.pc_next        = pc;
            end
          endcase
          if (!ex.res.reg_we) begin
            ex.res.reg_index = '0;
          end
        end
      end
      default: begin
        ex = '0;
      end
    endcase

    ex.res.next_pc = ex.pc_next;
    ex.res.halted  = ex.halt_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/toy_cpu_instruction_executor.sv =====
`default_nettype none
// A request passes the operand stage register, then the result register.
// Throughput: one request per cycle while res_stall is low, set by the
// single execute stage with one memory access and one regfile write each.
// Reset: pc, halt flag and pipeline valids clear; register file and data
// memory read as zero through per-entry valid bits, so no clearing pass.
// ----------------------------------------------------------------------------
// toy_cpu_instruction_executor
// Two-stage executor: operand stage with bypass, then a result register
// with the data memory read alongside it.
// ----------------------------------------------------------------------------
module toy_cpu_instruction_executor (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire tcie_pkg::req_t   req,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output tcie_pkg::res_t        res
);

  logic              req_accept;
  logic              res_accept;
  logic              a_valid;
  logic              a_adv;
  tcie_pkg::req_t    a_item;
  logic              b_valid;
  tcie_pkg::res_t    b_res;
  logic              b_load;
  logic              b_read;
  tcie_pkg::byte_t   b_wval;
  tcie_pkg::byte_t   pc_q;
  logic              halt_q;
  tcie_pkg::byte_t   rd1;
  tcie_pkg::byte_t   rd2;
  tcie_pkg::byte_t   rd3;
  tcie_pkg::byte_t   op_a;
  tcie_pkg::byte_t   op_b;
  tcie_pkg::byte_t   op_c;
  tcie_pkg::byte_t   mem_rdata;
  tcie_pkg::exec_t   ex;

  // Handshakes
  assign a_adv      = a_valid && (!b_valid || !res_stall);
  assign req_stall  = rst || (a_valid && !a_adv);
  assign req_accept = req_valid && !req_stall;
  assign res_valid  = b_valid;
  assign res_accept = b_valid && !res_stall;

  // Register file, read as the request is taken
  tcie_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .rd_en (req_accept),
    .r1    (req.instr[11:8]),
    .r2    (req.instr[7:4]),
    .r3    (req.instr[3:0]),
    .we    (res_accept && b_res.reg_we),
    .widx  (b_res.reg_index),
    .wval  (b_wval),
    .rd1   (rd1),
    .rd2   (rd2),
    .rd3   (rd3)
  );

  // Bypass the pending write of the result stage
  assign b_wval = b_load ? mem_rdata : b_res.reg_value;
  assign op_a = (b_valid && b_res.reg_we && b_res.reg_index == a_item.instr[7:4])
                ? b_wval : rd2;
  assign op_b = (b_valid && b_res.reg_we && b_res.reg_index == a_item.instr[3:0])
                ? b_wval : rd3;
  assign op_c = (b_valid && b_res.reg_we && b_res.reg_index == a_item.instr[11:8])
                ? b_wval : rd1;

  tcie_exec u_exec (
    .req  (a_item),
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .pc   (pc_q),
    .halt (halt_q),
    .ex   (ex)
  );

  tcie_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .en    (a_adv),
    .req   (ex.mem),
    .rdata (mem_rdata)
  );

  // Operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      a_item <= req;
    end
  end

  // Architectural pc and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
    end else if (a_adv) begin
      pc_q   <= ex.pc_next;
      halt_q <= ex.halt_next;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (res_accept) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_res  <= ex.res;
      b_load <= ex.is_load;
      b_read <= ex.is_read;
    end
  end

  // Memory data joins the result here
  always_comb begin
    res = b_res;
    if (b_load) begin
      res.reg_value = mem_rdata;
    end
    if (b_read) begin
      res.read_data = mem_rdata;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  a_halt_pc_hold: assert property (@(posedge clk) disable iff (rst)
    halt_q |=> $stable(pc_q))
    else $error("pc moved while halted");

  a_bad_no_effect: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bad_opcode |-> !res.reg_we && !res.mem_we && !res.branch_taken)
    else $error("flagged opcode changed state");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rst || (a_valid && b_valid && res_stall))
    else $error("request stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ===== sim/toy_cpu_instruction_executor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_instruction_executor_test
// Drives execute, preload and read requests into the executor and checks
// each result against a fixed value or an in-bench model of the registers,
// memory, pc and halt flag. A short directed table runs first, then random
// traffic with random gaps and result stalls, then a halt sequence.
// ----------------------------------------------------------------------------
module toy_cpu_instruction_executor_test;

  // Unassigned opcodes
  localparam logic [3:0] OP_BAD_FIRST = 4'd12;
  localparam logic [3:0] OP_BAD_MID   = 4'd13;
  localparam logic [3:0] OP_BAD_LAST  = 4'd14;

  localparam int N_LEAD   = 26;    // table rows run before the random part
  localparam int N_ROWS   = 33;
  localparam int N_RANDOM = 2000;
  localparam int PAUSE_AT = 1200;  // random request after which the sender drains
  localparam int HOLD_AT  = 700;   // results seen before the long result stall
  localparam int TAIL_CYC = 10;

  // Result fields: next_pc, halted, bad, taken, reg_we, reg_index, reg_value,
  // mem_we, mem_addr, mem_value, read_data
  localparam tcie_pkg::res_t EXP_CLEAR = '0;
  localparam tcie_pkg::res_t EXP_BAD   = {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 4'h0, 8'h00,
                                          1'b0, 8'h00, 8'h00, 8'h00};
  localparam tcie_pkg::res_t EXP_R15FF = {8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'hF, 8'hFF,
                                          1'b0, 8'h00, 8'h00, 8'h00};
  localparam tcie_pkg::res_t EXP_R0_80 = {8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'h0, 8'h80,
                                          1'b0, 8'h00, 8'h00, 8'h00};
  localparam tcie_pkg::res_t EXP_MEMFF = {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 8'h00,
                                          1'b1, 8'hFF, 8'hFF, 8'h00};
  localparam tcie_pkg::res_t EXP_RD_FF = {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0, 8'h00,
                                          1'b0, 8'h00, 8'h00, 8'hFF};

  typedef struct packed {
    tcie_pkg::req_t rq;
    logic           fixed;   // 1: use want, 0: use the model
    tcie_pkg::res_t want;
  } row_t;

  // Directed requests: func, instr, addr, wdata, fixed, want
  row_t directed_rows [0:N_ROWS-1] = '{
    {tcie_pkg::FUNC_RDMEM, 16'h0000, 8'h00, 8'h00, 1'b1, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, OP_BAD_FIRST, 4'h1, 4'h2, 4'h3, 8'h00, 8'h00, 1'b1, EXP_BAD},
    {tcie_pkg::FUNC_EXEC, OP_BAD_MID, 4'hF, 4'hF, 4'hF, 8'hFF, 8'hFF, 1'b1, EXP_BAD},
    {tcie_pkg::FUNC_EXEC, OP_BAD_LAST, 4'h0, 4'h0, 4'h0, 8'h00, 8'h00, 1'b1, EXP_BAD},
    {tcie_pkg::FUNC_LDREG, 16'h0000, 8'hFF, 8'hFF, 1'b1, EXP_R15FF},
    {tcie_pkg::FUNC_LDREG, 16'hFFFF, 8'h10, 8'h80, 1'b1, EXP_R0_80},
    {tcie_pkg::FUNC_LDMEM, 16'h0000, 8'hFF, 8'hFF, 1'b1, EXP_MEMFF},
    {tcie_pkg::FUNC_RDMEM, 16'h0000, 8'hFF, 8'h00, 1'b1, EXP_RD_FF},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_ADD, 4'h1, 4'hF, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_SUB, 4'h2, 4'h0, 4'hF, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_MUL, 4'h3, 4'hF, 4'hF, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_INC, 4'hF, 4'h0, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_AND, 4'h4, 4'h1, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_OR, 4'h5, 4'h2, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_NOT, 4'h6, 4'hF, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_XOR, 4'h7, 4'h0, 4'h1, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_LOAD, 4'h8, 4'h0, 4'h7, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_LOAD, 4'h9, 4'h1, 4'h8, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_STORE, 4'h0, 4'h0, 4'hF, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_STORE, 4'h6, 4'h6, 4'h7, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_LOAD, 4'hA, 4'hF, 4'hF, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_JUMP, 8'h7F, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_JUMP, 8'h80, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_BEQZ, 4'hF, 8'h80, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_BEQZ, 4'h0, 8'h7F, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_RDMEM, 16'h0000, 8'h7F, 8'h00, 1'b0, EXP_CLEAR},
    // halt and what follows it, run after the random part
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_HALT, 4'h0, 4'h0, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_ADD, 4'h1, 4'h1, 4'h1, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, OP_BAD_FIRST, 4'h0, 4'h0, 4'h0, 8'h00, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_LDREG, 16'h0000, 8'h03, 8'h5A, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_LDMEM, 16'h0000, 8'h80, 8'hA5, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_RDMEM, 16'h0000, 8'h80, 8'h00, 1'b0, EXP_CLEAR},
    {tcie_pkg::FUNC_EXEC, tcie_pkg::OP_HALT, 4'hF, 4'hF, 4'hF, 8'h00, 8'h00, 1'b0, EXP_CLEAR}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  tcie_pkg::req_t req = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  tcie_pkg::res_t res;

  // Model state
  tcie_pkg::byte_t arch_regs [tcie_pkg::NUM_REGS];
  tcie_pkg::byte_t arch_mem [tcie_pkg::DMEM_DEPTH];
  tcie_pkg::byte_t arch_pc;
  logic            arch_halted;

  tcie_pkg::res_t expected_q [$];
  int             mismatches = 0;
  int             results_seen = 0;

  toy_cpu_instruction_executor uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;
    arch_halted = 1'b0;
  end

  // Apply one request to the model and return the result it should give
  function automatic tcie_pkg::res_t step_executor(tcie_pkg::req_t r);
    tcie_pkg::res_t     o;
    logic [3:0]         op;
    tcie_pkg::reg_idx_t ra, rb, rc;
    tcie_pkg::byte_t    a, b, ea, npc;
    o  = '0;
    op = r.instr[15:12];
    ra = r.instr[11:8];
    rb = r.instr[7:4];
    rc = r.instr[3:0];
    a  = arch_regs[rb];
    b  = arch_regs[rc];
    ea = a + {{4{rc[3]}}, rc};
    case (r.func)
      tcie_pkg::FUNC_LDREG: begin
        o.reg_we    = 1'b1;
        o.reg_index = r.addr[3:0];
        o.reg_value = r.wdata;
        arch_regs[r.addr[3:0]] = r.wdata;
      end
      tcie_pkg::FUNC_LDMEM: begin
        o.mem_we    = 1'b1;
        o.mem_addr  = r.addr;
        o.mem_value = r.wdata;
        arch_mem[r.addr % tcie_pkg::DMEM_DEPTH] = r.wdata;
      end
      tcie_pkg::FUNC_RDMEM: begin
        o.read_data = arch_mem[r.addr % tcie_pkg::DMEM_DEPTH];
      end
      default: begin
        // execute; ignored entirely once halted
        if (!arch_halted) begin
          npc = arch_pc + 8'd2;
          case (op)
            tcie_pkg::OP_ADD: begin o.reg_value = a + b; o.reg_we = 1'b1; end
            tcie_pkg::OP_SUB: begin o.reg_value = a - b; o.reg_we = 1'b1; end
            tcie_pkg::OP_MUL: begin o.reg_value = a * b; o.reg_we = 1'b1; end
            tcie_pkg::OP_INC: begin
              o.reg_value = arch_regs[ra] + 8'd1;
              o.reg_we    = 1'b1;
            end
            tcie_pkg::OP_AND: begin o.reg_value = a & b; o.reg_we = 1'b1; end
            tcie_pkg::OP_OR:  begin o.reg_value = a | b; o.reg_we = 1'b1; end
            tcie_pkg::OP_NOT: begin o.reg_value = ~a; o.reg_we = 1'b1; end
            tcie_pkg::OP_XOR: begin o.reg_value = a ^ b; o.reg_we = 1'b1; end
            tcie_pkg::OP_LOAD: begin
              o.reg_value = arch_mem[ea % tcie_pkg::DMEM_DEPTH];
              o.reg_we    = 1'b1;
              o.mem_addr  = ea;
            end
            tcie_pkg::OP_STORE: begin
              o.mem_we    = 1'b1;
              o.mem_addr  = ea;
              o.mem_value = arch_regs[ra];
              arch_mem[ea % tcie_pkg::DMEM_DEPTH] = arch_regs[ra];
            end
            tcie_pkg::OP_JUMP: begin
              npc = npc + {r.instr[10:4], 1'b0};
              o.branch_taken = 1'b1;
            end
            tcie_pkg::OP_BEQZ: begin
              if (arch_regs[ra] == '0) begin
                npc = npc + {r.instr[6:0], 1'b0};
                o.branch_taken = 1'b1;
              end
            end
            tcie_pkg::OP_HALT: begin
              arch_halted = 1'b1;
            end
            default: begin
              o.bad_opcode = 1'b1;
              npc = arch_pc;
            end
          endcase
          if (o.reg_we) begin
            o.reg_index = ra;
            arch_regs[ra] = o.reg_value;
          end
          arch_pc = npc;
        end
      end
    endcase
    o.next_pc = arch_pc;
    o.halted  = arch_halted;
    return o;
  endfunction

  // Random request: mostly executes with legal opcodes, no halts
  function automatic tcie_pkg::req_t random_request();
    tcie_pkg::req_t r;
    int             p;
    r.instr = 16'($urandom);
    r.addr  = 8'($urandom);
    r.wdata = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 75)      r.func = tcie_pkg::FUNC_EXEC;
    else if (p < 87) r.func = tcie_pkg::FUNC_LDREG;
    else if (p < 94) r.func = tcie_pkg::FUNC_LDMEM;
    else             r.func = tcie_pkg::FUNC_RDMEM;
    if ($urandom_range(0, 49) == 0)
      r.instr[15:12] = 4'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    else
      r.instr[15:12] = 4'($urandom_range(tcie_pkg::OP_ADD, tcie_pkg::OP_BEQZ));
    return r;
  endfunction

  // Idle cycles after a request; none inside a burst
  function automatic int idle_gap(bit burst);
    int p;
    p = $urandom_range(0, 99);
    if (burst || p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, wait for acceptance, record the expected result
  task automatic push_request(tcie_pkg::req_t r, int gap, logic fixed,
                              tcie_pkg::res_t fixed_res);
    logic           took;
    tcie_pkg::res_t guess;
    req       <= r;
    req_valid <= 1'b1;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !req_stall;
      @(posedge clk);
    end
    guess = step_executor(r);
    expected_q.insert(expected_q.size(), fixed ? fixed_res : guess);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
    mismatches++;
    $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  // Result checker; inputs only change at rising edges, so sample on falling
  always @(negedge clk) begin
    tcie_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, res);
      end else begin
        want = expected_q.pop_front();
        if (res.next_pc !== want.next_pc)
          note_mismatch("next_pc", want.next_pc, res.next_pc);
        if (res.halted !== want.halted)
          note_mismatch("halted", want.halted, res.halted);
        if (res.bad_opcode !== want.bad_opcode)
          note_mismatch("bad_opcode", want.bad_opcode, res.bad_opcode);
        if (res.branch_taken !== want.branch_taken)
          note_mismatch("branch_taken", want.branch_taken, res.branch_taken);
        if (res.reg_we !== want.reg_we)
          note_mismatch("reg_we", want.reg_we, res.reg_we);
        if (res.reg_index !== want.reg_index)
          note_mismatch("reg_index", want.reg_index, res.reg_index);
        if (res.reg_value !== want.reg_value)
          note_mismatch("reg_value", want.reg_value, res.reg_value);
        if (res.mem_we !== want.mem_we)
          note_mismatch("mem_we", want.mem_we, res.mem_we);
        if (res.mem_addr !== want.mem_addr)
          note_mismatch("mem_addr", want.mem_addr, res.mem_addr);
        if (res.mem_value !== want.mem_value)
          note_mismatch("mem_value", want.mem_value, res.mem_value);
        if (res.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, res.read_data);
      end
    end
  end

  // Result side stalls: quiet stretches, short and long stalls, one long hold
  initial begin : result_side
    int   span;
    int   p;
    logic hold;
    bit   long_done;
    long_done = 1'b0;
    forever begin
      if (!long_done && results_seen >= HOLD_AT) begin
        long_done = 1'b1;
        hold = 1'b1;
        span = 300;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 45) begin
          hold = 1'b0;
          span = $urandom_range(1, 30);
        end else if (p < 92) begin
          hold = 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          hold = 1'b1;
          span = $urandom_range(8, 30);
        end
      end
      @(posedge clk);
      res_stall <= hold;
      repeat (span - 1) @(posedge clk);
    end
  end

  // Stimulus
  initial begin : request_side
    int i;
    int gap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (i = 0; i < N_LEAD; i++)
      push_request(directed_rows[i].rq, idle_gap(1'b0), directed_rows[i].fixed,
                   directed_rows[i].want);

    // random traffic, with bursts and one full drain midway
    for (i = 0; i < N_RANDOM; i++) begin
      gap = (i == PAUSE_AT) ? 1 : idle_gap((i % 300) < 80);
      push_request(random_request(), gap, 1'b0, EXP_CLEAR);
      if (i == PAUSE_AT) drain_results();
    end

    // halt, then requests while halted
    for (i = N_LEAD; i < N_ROWS; i++) begin
      gap = (i == N_ROWS - 1) ? 1 : idle_gap(1'b0);
      push_request(directed_rows[i].rq, gap, directed_rows[i].fixed,
                   directed_rows[i].want);
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
